/* rtl/dssm_pkg.sv */
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types, codes and widths for the dual stack shared memory core.
// ----------------------------------------------------------------------------
package dssm_pkg;

   localparam int unsigned DEPTH_DEFAULT = 256;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned REQ_TDATA_W   = 40;
   localparam int unsigned RSP_TDATA_W   = 40;

   typedef logic [1:0] command_type;
   typedef logic [1:0] status_type;

   localparam command_type CMD_PUSH = 2'd0;
   localparam command_type CMD_POP  = 2'd1;
   localparam command_type CMD_PEEK = 2'd2;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OVERFLOW  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   // Response information that is known at request time and waits in the first
   // stage for the memory read data.
   typedef struct packed {
      logic       use_mem;
      status_type status;
      logic       lower_empty;
      logic       upper_empty;
   } rsp_meta_type;

endpackage

/* rtl/dssm_mem.sv */
// ----------------------------------------------------------------------------
// dssm_mem
// Single port synchronous word memory with a registered read port.
// ----------------------------------------------------------------------------
module dssm_mem import dssm_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [AW-1:0]     addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/dssm_ctl.sv */
// ----------------------------------------------------------------------------
// dssm_ctl
// Stack occupancy counters, bounds checks and memory address generation.
// ----------------------------------------------------------------------------
module dssm_ctl import dssm_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH),
   parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  command_type   command,
   input  logic          stack_sel,
   output logic          mem_wr,
   output logic          mem_rd,
   output logic [AW-1:0] mem_addr,
   output rsp_meta_type  meta
);

   localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);

   logic [CW-1:0] lower_count_ff, lower_count_in;
   logic [CW-1:0] upper_count_ff, upper_count_in;
   logic [CW:0]   total;
   logic          full;
   logic          sel_empty;
   logic [CW-1:0] lower_top, upper_top, upper_push;
   logic [CW-1:0] addr_full;

   assign total      = {1'b0, lower_count_ff} + {1'b0, upper_count_ff};
   assign full       = (total >= DEPTH_SUM);
   assign sel_empty  = stack_sel ? (upper_count_ff == '0) : (lower_count_ff == '0);
   assign lower_top  = lower_count_ff - ONE_CNT;
   assign upper_top  = DEPTH_CNT - upper_count_ff;
   assign upper_push = DEPTH_CNT - upper_count_ff - ONE_CNT;

   always_comb begin
      lower_count_in = lower_count_ff;
      upper_count_in = upper_count_ff;
      mem_wr         = 1'b0;
      mem_rd         = 1'b0;
      addr_full      = stack_sel ? upper_top : lower_top;
      meta.use_mem   = 1'b0;
      meta.status    = ST_OK;
      unique case (command) inside
         CMD_PUSH: begin
            addr_full = stack_sel ? upper_push : lower_count_ff;
            if (full) begin
               meta.status = ST_OVERFLOW;
            end else begin
               mem_wr = accept;
               if (stack_sel) begin
                  upper_count_in = upper_count_ff + ONE_CNT;
               end else begin
                  lower_count_in = lower_count_ff + ONE_CNT;
               end
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (sel_empty) begin
               meta.status = ST_UNDERFLOW;
            end else begin
               mem_rd       = accept;
               meta.use_mem = 1'b1;
               if (command == CMD_POP) begin
                  if (stack_sel) begin
                     upper_count_in = upper_count_ff - ONE_CNT;
                  end else begin
                     lower_count_in = lower_count_ff - ONE_CNT;
                  end
               end
            end
         end
         default: begin
            // Unused command: no state change, status stays ok.
         end
      endcase
      meta.lower_empty = (lower_count_in == '0);
      meta.upper_empty = (upper_count_in == '0);
   end

   assign mem_addr = addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_count_ff <= '0;
         upper_count_ff <= '0;
      end else if (accept) begin
         lower_count_ff <= lower_count_in;
         upper_count_ff <= upper_count_in;
      end
   end

endmodule

/* rtl/dual_stack_shared_memory_core.sv */
// Each request passes the first stage (memory access and meta) and then the
// output register. Throughput: one request per cycle while the output drains;
// counters update at acceptance and the memory is read or written at most once
// per request, so requests follow back to back. A finished response waits in
// the output register while the next request's memory read is in flight. Reset
// (synchronous) empties both stacks at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_core
// Two LIFO stacks sharing one word memory, lower stack growing up from
// address zero and upper stack growing down from the last address.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_core import dssm_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] command, [2] stack_sel, [34:3] push_value, [39:35] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] read_value, [33:32] status, [34] lower_empty, [35] upper_empty,
   // [39:36] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   command_type        command;
   logic               stack_sel;
   logic signed [31:0] push_value;
   logic               accept;
   logic               advance;
   logic               mem_wr, mem_rd;
   logic [AW-1:0]      mem_addr;
   logic [DATA_W-1:0]  mem_rdata;
   rsp_meta_type       meta;

   logic               s1_valid_ff, s1_valid_in;
   rsp_meta_type       s1_meta_ff;
   logic               out_valid_ff, out_valid_in;
   logic signed [31:0] read_value_ff;
   status_type         status_ff;
   logic               lower_empty_ff, upper_empty_ff;

   assign command    = req_tdata[1:0];
   assign stack_sel  = req_tdata[2];
   assign push_value = req_tdata[34:3];

   // The second stage moves on when the output register is free or drains.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   dssm_ctl #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .CW   (CW)
   ) u_ctl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .command  (command),
      .stack_sel(stack_sel),
      .mem_wr   (mem_wr),
      .mem_rd   (mem_rd),
      .mem_addr (mem_addr),
      .meta     (meta)
   );

   dssm_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock(clock),
      .wr_en(mem_wr),
      .rd_en(mem_rd),
      .addr (mem_addr),
      .wdata(push_value),
      .rdata(mem_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (advance) begin
         read_value_ff  <= s1_meta_ff.use_mem ? mem_rdata : '0;
         status_ff      <= s1_meta_ff.status;
         lower_empty_ff <= s1_meta_ff.lower_empty;
         upper_empty_ff <= s1_meta_ff.upper_empty;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, upper_empty_ff, lower_empty_ff, status_ff, read_value_ff};

endmodule
